/* rtl/lpai_pkg.sv */
package lpai_pkg;

   localparam int COORD_BITS = 12;
   localparam int INDEX_BITS = 12;

   // dividend is idx * short + long - 1, which stays below long * 2**COORD_BITS
   localparam int NUM_BITS = 2 * COORD_BITS;
   localparam int CMP_BITS = (INDEX_BITS > COORD_BITS) ? INDEX_BITS : COORD_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [COORD_BITS-1:0]        span_type;
   typedef logic [INDEX_BITS-1:0]        index_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      index_type step_index;
   } req_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      logic      beyond_end;
      logic      x_is_major;
   } rsp_type;

endpackage

/* rtl/line_point_at_index_unit.sv */
// Line point at index. Each request word carries two endpoints and a step
// index; the response word is the raster point at that step. The long axis
// is the one with the larger span (a tie goes to y). The point moves by the
// index along the long axis and by ceil(index * short / long) along the
// short axis, each axis stepping away from the first endpoint. An index past
// the long span is clamped to it and flagged; a zero-length line returns the
// first endpoint. The unit takes a word in every cycle (busy never rises)
// and returns each result through four setup stages (spans, axis pick and
// clamp, multiply, dividend), one restoring-divider stage per quotient bit,
// and the output stage. The receiver cannot stall: rsp_strobe marks each
// result for a single cycle and the word must be taken then.
module line_point_at_index_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  lpai_pkg::req_type req_word,
   output logic             busy,
   output logic             rsp_strobe,
   output lpai_pkg::rsp_type rsp_word
);
   import lpai_pkg::*;

   // per-word control that rides along the pipe
   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      logic      dir_x;     // 1: step upward from start_x
      logic      dir_y;
      logic      x_major;
      logic      beyond;
      span_type  idx;       // clamped index, always <= long span
   } side_type;

   // ---------------------------------------------------------------------
   // Stage 1: spans and step directions
   // ---------------------------------------------------------------------
   logic                  s1_valid_ff;
   coord_type             s1_start_x_ff, s1_start_y_ff;
   logic                  s1_dir_x_ff, s1_dir_y_ff;
   span_type              s1_span_x_ff, s1_span_y_ff;
   index_type             s1_index_ff;

   logic [COORD_BITS:0]   dx_fwd, dx_rev, dy_fwd, dy_rev;
   span_type              s1_span_x_in, s1_span_y_in;

   always_comb begin
      dx_fwd = {req_word.end_x[COORD_BITS-1], req_word.end_x}
             - {req_word.start_x[COORD_BITS-1], req_word.start_x};
      dx_rev = {req_word.start_x[COORD_BITS-1], req_word.start_x}
             - {req_word.end_x[COORD_BITS-1], req_word.end_x};
      dy_fwd = {req_word.end_y[COORD_BITS-1], req_word.end_y}
             - {req_word.start_y[COORD_BITS-1], req_word.start_y};
      dy_rev = {req_word.start_y[COORD_BITS-1], req_word.start_y}
             - {req_word.end_y[COORD_BITS-1], req_word.end_y};
      s1_span_x_in = (req_word.start_x > req_word.end_x) ? dx_rev[COORD_BITS-1:0]
                                                         : dx_fwd[COORD_BITS-1:0];
      s1_span_y_in = (req_word.start_y > req_word.end_y) ? dy_rev[COORD_BITS-1:0]
                                                         : dy_fwd[COORD_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
      s1_start_x_ff <= req_word.start_x;
      s1_start_y_ff <= req_word.start_y;
      s1_dir_x_ff   <= (req_word.start_x <= req_word.end_x);
      s1_dir_y_ff   <= (req_word.start_y <= req_word.end_y);
      s1_span_x_ff  <= s1_span_x_in;
      s1_span_y_ff  <= s1_span_y_in;
      s1_index_ff   <= req_word.step_index;
   end

   // ---------------------------------------------------------------------
   // Stage 2: long/short axis pick, index clamp
   // ---------------------------------------------------------------------
   logic                  s2_valid_ff;
   side_type              s2_side_ff;
   span_type              s2_long_ff, s2_short_ff;

   side_type              s2_side_in;
   span_type              s2_long_in, s2_short_in;
   logic [CMP_BITS-1:0]   index_ext, long_ext;

   always_comb begin
      s2_side_in.start_x = s1_start_x_ff;
      s2_side_in.start_y = s1_start_y_ff;
      s2_side_in.dir_x   = s1_dir_x_ff;
      s2_side_in.dir_y   = s1_dir_y_ff;
      s2_side_in.x_major = (s1_span_x_ff > s1_span_y_ff);
      s2_long_in  = s2_side_in.x_major ? s1_span_x_ff : s1_span_y_ff;
      s2_short_in = s2_side_in.x_major ? s1_span_y_ff : s1_span_x_ff;
      index_ext   = CMP_BITS'(s1_index_ff);
      long_ext    = CMP_BITS'(s2_long_in);
      s2_side_in.beyond = (index_ext > long_ext);
      s2_side_in.idx    = s2_side_in.beyond ? s2_long_in : index_ext[COORD_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_side_ff  <= s2_side_in;
      s2_long_ff  <= s2_long_in;
      s2_short_ff <= s2_short_in;
   end

   // ---------------------------------------------------------------------
   // Stage 3: idx * short
   // ---------------------------------------------------------------------
   logic                  s3_valid_ff;
   side_type              s3_side_ff;
   span_type              s3_long_ff;
   logic [NUM_BITS-1:0]   s3_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_side_ff <= s2_side_ff;
      s3_long_ff <= s2_long_ff;
      s3_prod_ff <= NUM_BITS'(s2_side_ff.idx) * NUM_BITS'(s2_short_ff);
   end

   // ---------------------------------------------------------------------
   // Stage 4: ceiling dividend; zero-length line forced to zero
   // ---------------------------------------------------------------------
   logic                  s4_valid_ff;
   side_type              s4_side_ff;
   span_type              s4_long_ff;
   logic                  s4_zero_ff;
   logic [NUM_BITS-1:0]   s4_num_ff;

   logic                  s4_zero_in;

   assign s4_zero_in = (s3_long_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_side_ff <= s3_side_ff;
      s4_long_ff <= s3_long_ff;
      s4_zero_ff <= s4_zero_in;
      s4_num_ff  <= s4_zero_in ? '0 : (s3_prod_ff + NUM_BITS'(s3_long_ff) - NUM_BITS'(1));
   end

   // ---------------------------------------------------------------------
   // Divider: one quotient bit per stage, restoring. The quotient fits in
   // COORD_BITS, so the high half of the dividend starts below the divisor.
   // ---------------------------------------------------------------------
   logic                  dv_valid_ff [COORD_BITS];
   side_type              dv_side_ff  [COORD_BITS];
   span_type              dv_long_ff  [COORD_BITS];
   logic                  dv_zero_ff  [COORD_BITS];
   span_type              dv_rem_ff   [COORD_BITS];
   span_type              dv_low_ff   [COORD_BITS];
   span_type              dv_quo_ff   [COORD_BITS];

   logic                  dv_valid_src [COORD_BITS];
   side_type              dv_side_src  [COORD_BITS];
   span_type              dv_long_src  [COORD_BITS];
   logic                  dv_zero_src  [COORD_BITS];
   span_type              dv_rem_src   [COORD_BITS];
   span_type              dv_low_src   [COORD_BITS];
   span_type              dv_quo_src   [COORD_BITS];
   logic [COORD_BITS:0]   dv_trial     [COORD_BITS];
   logic [COORD_BITS:0]   dv_diff      [COORD_BITS];
   logic                  dv_ge        [COORD_BITS];
   span_type              dv_rem_in    [COORD_BITS];
   span_type              dv_low_in    [COORD_BITS];
   span_type              dv_quo_in    [COORD_BITS];

   always_comb begin
      for (int k = 0; k < COORD_BITS; k++) begin
         if (k == 0) begin
            dv_valid_src[k] = s4_valid_ff;
            dv_side_src[k]  = s4_side_ff;
            dv_long_src[k]  = s4_long_ff;
            dv_zero_src[k]  = s4_zero_ff;
            dv_rem_src[k]   = s4_num_ff[NUM_BITS-1:COORD_BITS];
            dv_low_src[k]   = s4_num_ff[COORD_BITS-1:0];
            dv_quo_src[k]   = '0;
         end else begin
            dv_valid_src[k] = dv_valid_ff[k-1];
            dv_side_src[k]  = dv_side_ff[k-1];
            dv_long_src[k]  = dv_long_ff[k-1];
            dv_zero_src[k]  = dv_zero_ff[k-1];
            dv_rem_src[k]   = dv_rem_ff[k-1];
            dv_low_src[k]   = dv_low_ff[k-1];
            dv_quo_src[k]   = dv_quo_ff[k-1];
         end
         dv_trial[k]  = {dv_rem_src[k], dv_low_src[k][COORD_BITS-1]};
         dv_diff[k]   = dv_trial[k] - {1'b0, dv_long_src[k]};
         dv_ge[k]     = (dv_trial[k] >= {1'b0, dv_long_src[k]});
         dv_rem_in[k] = dv_ge[k] ? dv_diff[k][COORD_BITS-1:0] : dv_trial[k][COORD_BITS-1:0];
         dv_low_in[k] = {dv_low_src[k][COORD_BITS-2:0], 1'b0};
         dv_quo_in[k] = {dv_quo_src[k][COORD_BITS-2:0], dv_ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < COORD_BITS; k++) begin
         if (reset) begin
            dv_valid_ff[k] <= 1'b0;
         end else begin
            dv_valid_ff[k] <= dv_valid_src[k];
         end
         dv_side_ff[k] <= dv_side_src[k];
         dv_long_ff[k] <= dv_long_src[k];
         dv_zero_ff[k] <= dv_zero_src[k];
         dv_rem_ff[k]  <= dv_rem_in[k];
         dv_low_ff[k]  <= dv_low_in[k];
         dv_quo_ff[k]  <= dv_quo_in[k];
      end
   end

   // ---------------------------------------------------------------------
   // Output stage: step each axis away from the first endpoint
   // ---------------------------------------------------------------------
   logic                  rsp_strobe_ff;
   rsp_type               rsp_word_ff;

   side_type              fin_side;
   span_type              minor_step, step_x, step_y;
   rsp_type               rsp_word_in;

   always_comb begin
      fin_side   = dv_side_ff[COORD_BITS-1];
      minor_step = dv_zero_ff[COORD_BITS-1] ? '0 : dv_quo_ff[COORD_BITS-1];
      step_x     = fin_side.x_major ? fin_side.idx : minor_step;
      step_y     = fin_side.x_major ? minor_step : fin_side.idx;
      // results stay between the endpoints, so wrapping at COORD_BITS is exact
      rsp_word_in.point_x = fin_side.dir_x ? coord_type'(span_type'(fin_side.start_x) + step_x)
                                           : coord_type'(span_type'(fin_side.start_x) - step_x);
      rsp_word_in.point_y = fin_side.dir_y ? coord_type'(span_type'(fin_side.start_y) + step_y)
                                           : coord_type'(span_type'(fin_side.start_y) - step_y);
      rsp_word_in.beyond_end = fin_side.beyond;
      rsp_word_in.x_is_major = fin_side.x_major;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dv_valid_ff[COORD_BITS-1];
      end
      rsp_word_ff <= rsp_word_in;
   end

   // fully pipelined, nothing ever holds the front end off
   assign busy       = 1'b0;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule
